[rtl/core/qoi_pixel_encoder_defines.svh]
// Assertion macros shared by the QOI pixel encoder RTL.
`ifndef QOI_PIXEL_ENCODER_DEFINES_SVH
`define QOI_PIXEL_ENCODER_DEFINES_SVH

// Property that must hold at every rising clock edge outside reset.
`define QOI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition that must be followed by a consequence in the next cycle.
`define QOI_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/core/qoi_pkg.sv]
// Shared types, opcodes and helpers of the QOI pixel encoder.
package qoi_pkg;

  // Chunk opcodes
  localparam logic [7:0] OpIndex = 8'h00;
  localparam logic [7:0] OpDiff  = 8'h40;
  localparam logic [7:0] OpLuma  = 8'h80;
  localparam logic [7:0] OpRun   = 8'hC0;
  localparam logic [7:0] OpRgb   = 8'hFE;
  localparam logic [7:0] OpRgba  = 8'hFF;

  localparam int unsigned IndexSize  = 64;
  localparam int unsigned IndexW     = $clog2(IndexSize);
  localparam int unsigned RunW       = 6;
  localparam logic [RunW-1:0] RunLimit = 6'd62;
  localparam int unsigned MaxBytes   = 6;
  localparam int unsigned NumBytesW  = $clog2(MaxBytes + 1);
  localparam int unsigned ByteIdxW   = $clog2(MaxBytes);
  localparam int unsigned QoiCmdDepth = 4;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  localparam pixel_t ResetPixel = 32'h0000_00FF;

  // One pixel's worth of encoded bytes, bytes[0] goes out first
  typedef struct packed {
    logic [NumBytesW-1:0]          nbytes;
    logic [MaxBytes-1:0][7:0]      bytes;
  } cmd_t;

  // Index position: (r*3 + g*5 + b*7 + a*11) mod 64
  function automatic logic [IndexW-1:0] qoi_hash(pixel_t p);
    logic [IndexW-1:0] sum;
    sum = p.r[IndexW-1:0] * IndexW'(3) + p.g[IndexW-1:0] * IndexW'(5)
        + p.b[IndexW-1:0] * IndexW'(7) + p.a[IndexW-1:0] * IndexW'(11);
    return sum;
  endfunction

endpackage

[rtl/core/qoi_front.sv]
// Front end: pixel intake, colour index memory and chunk classification.
`include "qoi_pixel_encoder_defines.svh"
module qoi_front import qoi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       alpha_enable_i,
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [7:0] alpha_i,
  input  logic       first_pixel_i,
  input  logic       last_pixel_i,
  output cmd_t       cmd_o,
  output logic       cmd_push_o,
  input  logic       cmd_full_i
);

  logic              alpha_en_q;
  logic [7:0]        last_a_q;
  logic              accept;
  logic [7:0]        a_in;
  pixel_t            px_in;
  logic [IndexW-1:0] pos_in;

  logic              s1_valid_q;
  pixel_t            s1_px_q;
  logic [IndexW-1:0] s1_pos_q;
  logic              s1_first_q;
  logic              s1_last_q;

  pixel_t            index_mem [IndexSize];
  pixel_t            rd_q;
  logic              byp_hit_q;
  pixel_t            byp_data_q;
  logic [IndexSize-1:0] idx_valid_q, idx_valid_d;

  pixel_t            prev_q;
  logic [RunW-1:0]   run_q, run_d;

  pixel_t            prev_eff;
  logic [RunW-1:0]   run_eff;
  logic [RunW-1:0]   run_inc;
  pixel_t            entry;
  logic              same;
  logic              hit;
  logic              commit;
  logic              idx_wr;
  logic [7:0]        vr, vg, vb, vgr, vgb;
  logic [7:0]        dr2, dg2, db2, lg, lr, lb;
  logic              is_diff, is_luma;
  logic [4:0][7:0]   chunk;
  logic [NumBytesW-1:0] nc;
  logic              has_run;
  logic [7:0]        run_byte;
  cmd_t              cmd;

  // Configuration register; the user must write it only while idle (not enforced here)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_en_q <= 1'b1;
    end else if (cfg_valid_i) begin
      alpha_en_q <= alpha_enable_i;
    end
  end

  // Intake: resolve alpha and hash position at transfer time
  assign accept = push_i && !full_o;
  assign a_in   = alpha_en_q ? alpha_i : (first_pixel_i ? ResetPixel.a : last_a_q);
  assign px_in  = '{r: red_i, g: green_i, b: blue_i, a: a_in};
  assign pos_in = qoi_hash(px_in);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_a_q   <= ResetPixel.a;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        last_a_q <= a_in;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (commit) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q    <= px_in;
      s1_pos_q   <= pos_in;
      s1_first_q <= first_pixel_i;
      s1_last_q  <= last_pixel_i;
    end
  end

  // Index memory; a write at the read edge is forwarded through the bypass
  always_ff @(posedge clk_i) begin
    if (idx_wr) begin
      index_mem[s1_pos_q] <= s1_px_q;
    end
    if (accept) begin
      rd_q       <= index_mem[pos_in];
      byp_hit_q  <= idx_wr && (s1_pos_q == pos_in);
      byp_data_q <= s1_px_q;
    end
  end

  // Entry valid bits, cleared at once by a first pixel
  always_comb begin
    idx_valid_d = idx_valid_q;
    if (commit && s1_first_q) begin
      idx_valid_d = '0;
    end
    if (idx_wr) begin
      idx_valid_d[s1_pos_q] = 1'b1;
    end
  end

  // Encoder state, moved on when the staged pixel commits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_valid_q <= '0;
      prev_q      <= ResetPixel;
      run_q       <= '0;
    end else if (commit) begin
      idx_valid_q <= idx_valid_d;
      prev_q      <= s1_px_q;
      run_q       <= run_d;
    end
  end

  // Effective state seen by the staged pixel
  assign prev_eff = s1_first_q ? ResetPixel : prev_q;
  assign run_eff  = s1_first_q ? '0 : run_q;
  assign run_inc  = run_eff + RunW'(1);
  assign entry    = s1_first_q ? pixel_t'('0) :
                    byp_hit_q ? byp_data_q :
                    idx_valid_q[s1_pos_q] ? rd_q : pixel_t'('0);
  assign same     = (s1_px_q == prev_eff);
  assign hit      = (entry == s1_px_q);

  // Channel differences, wrapped to 8 bits and biased
  assign vr  = s1_px_q.r - prev_eff.r;
  assign vg  = s1_px_q.g - prev_eff.g;
  assign vb  = s1_px_q.b - prev_eff.b;
  assign vgr = vr - vg;
  assign vgb = vb - vg;
  assign dr2 = vr + 8'd2;
  assign dg2 = vg + 8'd2;
  assign db2 = vb + 8'd2;
  assign lg  = vg + 8'd32;
  assign lr  = vgr + 8'd8;
  assign lb  = vgb + 8'd8;
  assign is_diff = (dr2 < 8'd4) && (dg2 < 8'd4) && (db2 < 8'd4);
  assign is_luma = (lg < 8'd64) && (lr < 8'd16) && (lb < 8'd16);

  // Chunk selection for a pixel that differs from the previous one
  always_comb begin
    chunk = '0;
    nc    = '0;
    if (hit) begin
      chunk[0] = OpIndex | {2'b00, s1_pos_q};
      nc       = NumBytesW'(1);
    end else if (s1_px_q.a == prev_eff.a) begin
      if (is_diff) begin
        chunk[0] = OpDiff | {2'b00, dr2[1:0], dg2[1:0], db2[1:0]};
        nc       = NumBytesW'(1);
      end else if (is_luma) begin
        chunk[0] = OpLuma | {2'b00, lg[5:0]};
        chunk[1] = {lr[3:0], lb[3:0]};
        nc       = NumBytesW'(2);
      end else begin
        chunk[0] = OpRgb;
        chunk[1] = s1_px_q.r;
        chunk[2] = s1_px_q.g;
        chunk[3] = s1_px_q.b;
        nc       = NumBytesW'(4);
      end
    end else begin
      chunk[0] = OpRgba;
      chunk[1] = s1_px_q.r;
      chunk[2] = s1_px_q.g;
      chunk[3] = s1_px_q.b;
      chunk[4] = s1_px_q.a;
      nc       = NumBytesW'(5);
    end
  end

  // Byte list: optional run flush, then the chunk; a repeat gives a run byte only at the limit or last pixel
  always_comb begin
    has_run = 1'b0;
    run_d   = '0;
    cmd     = '0;
    if (same) begin
      if (run_inc >= RunLimit || s1_last_q) begin
        cmd.bytes[0] = OpRun | {2'b00, run_eff};
        cmd.nbytes   = NumBytesW'(1);
      end else begin
        run_d = run_inc;
      end
    end else begin
      has_run = (run_eff != '0);
      if (has_run) begin
        cmd.bytes[0] = run_byte;
        for (int k = 0; k < 5; k++) begin
          cmd.bytes[k+1] = chunk[k];
        end
      end else begin
        for (int k = 0; k < 5; k++) begin
          cmd.bytes[k] = chunk[k];
        end
      end
      cmd.nbytes = nc + NumBytesW'(has_run);
    end
  end

  assign run_byte = OpRun | {2'b00, run_eff - RunW'(1)};

  // Commit when the byte list fits in the queue
  assign commit     = s1_valid_q && ((cmd.nbytes == '0) || !cmd_full_i);
  assign idx_wr     = commit && !same && !hit;
  assign full_o     = s1_valid_q && !commit;
  assign cmd_push_o = commit && (cmd.nbytes != '0);
  assign cmd_o      = cmd;

  `QOI_ASSERT_NEXT(a_accept_stages, accept, s1_valid_q, "accepted pixel not staged")
  `QOI_ASSERT(a_run_bound, run_q < RunLimit, "run count reached the flush limit")

endmodule

[rtl/core/qoi_cmd_fifo.sv]
// Queue of per-pixel byte lists between front end and serializer.
`include "qoi_pixel_encoder_defines.svh"
module qoi_cmd_fifo import qoi_pkg::*; #(
  parameter int unsigned Depth = QoiCmdDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entries_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `QOI_ASSERT(a_count_bound, count_q <= CntW'(Depth), "queue count overflow")
  `QOI_ASSERT(a_no_push_full, !(push_i && full_o), "push into a full queue")

endmodule

[rtl/core/qoi_back.sv]
// Back end: serializes queued byte lists onto the result port.
`include "qoi_pixel_encoder_defines.svh"
module qoi_back import qoi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic       cmd_empty_i,
  output logic       cmd_pop_o,
  output logic [7:0] out_byte_o,
  output logic       last_byte_o,
  output logic       empty_o,
  input  logic       pop_i
);

  cmd_t                cur_q;
  logic [ByteIdxW-1:0] idx_q;
  logic                busy_q;
  logic                is_last;
  logic                load;

  assign is_last   = (NumBytesW'(idx_q) == cur_q.nbytes - NumBytesW'(1));
  assign load      = !cmd_empty_i && (!busy_q || (pop_i && is_last));
  assign cmd_pop_o = load;

  // Current byte list and position within it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q && pop_i) begin
      if (is_last) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + ByteIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= cmd_i;
    end
  end

  // Result port
  assign empty_o     = !busy_q;
  assign out_byte_o  = cur_q.bytes[idx_q];
  assign last_byte_o = is_last;

  `QOI_ASSERT(a_idx_in_list, !busy_q || (NumBytesW'(idx_q) < cur_q.nbytes),
              "byte position past end of list")

endmodule

[rtl/core/qoi_pixel_encoder.sv]
// Top level of the QOI pixel encoder.
//
// Pixel channel (queue style): a pixel transfers at a rising edge with push
// high and full low. first_pixel_i restarts the colour index, run count and
// previous pixel; last_pixel_i flushes any pending run.
// Result channel (queue style): while empty is low the oldest chunk byte is
// on out_byte_o, last_byte_o marking the final byte of its pixel; it
// transfers at a rising edge with pop high and empty low.
// Configuration: alpha_enable_i is written when cfg_valid_i is high
// (cfg_ready_o is always high); change it only while the block is idle.
// A pixel passes the staging register, byte-list queue and serializer register.
// Throughput: one pixel per cycle into the classifier while full is low; the
// serializer sends one byte per cycle while pop is high, and a byte-list queue
// of CmdDepth entries (4 by default) absorbs bursts. A pixel that only extends
// a run gives no bytes and takes no queue entry.
// Reset: index empty, previous pixel (0,0,0,255), run zero, alpha enabled.
// A stalled receiver fills the queue, then full rises and holds the pixel.
module qoi_pixel_encoder import qoi_pkg::*; #(
  parameter int unsigned CmdDepth = QoiCmdDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       alpha_enable_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [7:0] alpha_i,
  input  logic       first_pixel_i,
  input  logic       last_pixel_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       last_byte_o
);

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;

  assign cfg_ready_o = 1'b1;

  // Intake and classification
  qoi_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .alpha_enable_i (alpha_enable_i),
    .push_i         (push),
    .full_o         (full),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .alpha_i        (alpha_i),
    .first_pixel_i  (first_pixel_i),
    .last_pixel_i   (last_pixel_i),
    .cmd_o          (front_cmd),
    .cmd_push_o     (cmd_push),
    .cmd_full_i     (cmd_full)
  );

  // Decoupling queue
  qoi_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (queue_cmd),
    .empty_o (cmd_empty)
  );

  // Byte serializer
  qoi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (queue_cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

[bench/qoi_pixel_encoder_test.sv]
// Self-checking testbench of the QOI pixel encoder: directed chunk cases, then random images.
module qoi_pixel_encoder_test;
  import qoi_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } chunk_byte_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       cfg_valid_i    = 1'b0;
  logic       alpha_enable_i = 1'b1;
  logic       push           = 1'b0;
  logic [7:0] red_i          = 8'd0;
  logic [7:0] green_i        = 8'd0;
  logic [7:0] blue_i         = 8'd0;
  logic [7:0] alpha_i        = 8'd0;
  logic       first_pixel_i  = 1'b0;
  logic       last_pixel_i   = 1'b0;
  logic       pop            = 1'b0;
  logic       cfg_ready_o;
  logic       full;
  logic       empty;
  logic [7:0] out_byte_o;
  logic       last_byte_o;

  // Encoder state mirror
  pixel_t      color_table [IndexSize];
  pixel_t      prev_px;
  int unsigned run_len;
  bit          alpha_en_mirror;

  chunk_byte_t pending_bytes[$];
  chunk_byte_t head_byte;
  int unsigned error_count    = 0;
  int unsigned idle_pct       = 0;
  int unsigned stall_left     = 0;
  bit          hold_off_req   = 1'b0;

  qoi_pixel_encoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .alpha_enable_i (alpha_enable_i),
    .push           (push),
    .full           (full),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .alpha_i        (alpha_i),
    .first_pixel_i  (first_pixel_i),
    .last_pixel_i   (last_pixel_i),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte_o),
    .last_byte_o    (last_byte_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Run guard
  initial begin
    #4800000;
    $display("Verification failed");
    $finish;
  end

  function automatic pixel_t make_px(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic [7:0] a);
    pixel_t p;
    p.r = r;
    p.g = g;
    p.b = b;
    p.a = a;
    return p;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic void clear_encoder_state();
    foreach (color_table[i]) color_table[i] = '0;
    prev_px = ResetPixel;
    run_len = 0;
  endfunction

  // Chunk bytes that one accepted pixel produces; updates the mirror state
  function automatic void encode_pixel(pixel_t in_px, bit first, bit last);
    logic [7:0]        chunk[$];
    pixel_t            px;
    int unsigned       pos;
    logic signed [7:0] dr, dg, db, dgr, dgb;
    int                vr, vg, vb, vgr, vgb;
    chunk_byte_t       cb;
    if (first) clear_encoder_state();
    px   = in_px;
    px.a = alpha_en_mirror ? in_px.a : prev_px.a;
    if (px == prev_px) begin
      run_len++;
      if (run_len >= RunLimit || last) begin
        chunk.push_back(OpRun | 8'(run_len - 1));
        run_len = 0;
      end
    end else begin
      if (run_len > 0) begin
        chunk.push_back(OpRun | 8'(run_len - 1));
        run_len = 0;
      end
      pos = (3 * px.r + 5 * px.g + 7 * px.b + 11 * px.a) % IndexSize;
      if (color_table[pos] == px) begin
        chunk.push_back(OpIndex | 8'(pos));
      end else begin
        color_table[pos] = px;
        if (px.a == prev_px.a) begin
          // channel deltas wrap to signed 8 bits
          dr  = px.r - prev_px.r;
          dg  = px.g - prev_px.g;
          db  = px.b - prev_px.b;
          dgr = dr - dg;
          dgb = db - dg;
          vr  = int'(dr);
          vg  = int'(dg);
          vb  = int'(db);
          vgr = int'(dgr);
          vgb = int'(dgb);
          if (vr > -3 && vr < 2 && vg > -3 && vg < 2 && vb > -3 && vb < 2) begin
            chunk.push_back(OpDiff | 8'(((vr + 2) << 4) | ((vg + 2) << 2) | (vb + 2)));
          end else if (vgr > -9 && vgr < 8 && vg > -33 && vg < 32
                       && vgb > -9 && vgb < 8) begin
            chunk.push_back(OpLuma | 8'(vg + 32));
            chunk.push_back(8'(((vgr + 8) << 4) | (vgb + 8)));
          end else begin
            chunk.push_back(OpRgb);
            chunk.push_back(px.r);
            chunk.push_back(px.g);
            chunk.push_back(px.b);
          end
        end else begin
          chunk.push_back(OpRgba);
          chunk.push_back(px.r);
          chunk.push_back(px.g);
          chunk.push_back(px.b);
          chunk.push_back(px.a);
        end
      end
    end
    prev_px = px;
    foreach (chunk[k]) begin
      cb.data = chunk[k];
      cb.last = (k == chunk.size() - 1);
      pending_bytes.push_back(cb);
    end
  endfunction

  // Offer one pixel, hold it until the transfer, then maybe pause
  task automatic send_pixel(input pixel_t p, input bit first, input bit last);
    int unsigned gap;
    push          <= 1'b1;
    red_i         <= p.r;
    green_i       <= p.g;
    blue_i        <= p.b;
    alpha_i       <= p.a;
    first_pixel_i <= first;
    last_pixel_i  <= last;
    do @(posedge clk_i); while (full);
    encode_pixel(p, first, last);
    gap = pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drain all expected bytes, then let pixels without bytes clear the pipe
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_alpha_enable(input bit value);
    wait_idle();
    cfg_valid_i    <= 1'b1;
    alpha_enable_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i     <= 1'b0;
    alpha_en_mirror  = value;
  endtask

  // Result side: check each transfer, then decide pop for the next cycle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected byte, expected none got %02h last %b",
                   $time, out_byte_o, last_byte_o);
          error_count++;
        end else begin
          head_byte = pending_bytes.pop_front();
          if (out_byte_o !== head_byte.data) begin
            $display("%0t: out_byte mismatch, expected %02h got %02h",
                     $time, head_byte.data, out_byte_o);
            error_count++;
          end
          if (last_byte_o !== head_byte.last) begin
            $display("%0t: last_byte mismatch, expected %b got %b",
                     $time, head_byte.last, last_byte_o);
            error_count++;
          end
        end
      end
      if (hold_off_req) begin
        stall_left   = 250;
        hold_off_req = 1'b0;
      end
      if (stall_left != 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // One of each chunk type, with a run flush and wrapped deltas
  task automatic test_chunk_types();
    idle_pct = 20;
    send_pixel(make_px(8'd0, 8'd0, 8'd0, 8'd255), 1'b1, 1'b0);
    send_pixel(make_px(8'd0, 8'd0, 8'd0, 8'd255), 1'b0, 1'b1);
    send_pixel(make_px(8'd255, 8'd1, 8'd0, 8'd255), 1'b1, 1'b0);
    send_pixel(make_px(8'd10, 8'd12, 8'd9, 8'd255), 1'b0, 1'b0);
    send_pixel(make_px(8'd200, 8'd50, 8'd100, 8'd255), 1'b0, 1'b0);
    send_pixel(make_px(8'd200, 8'd50, 8'd100, 8'd0), 1'b0, 1'b0);
    send_pixel(make_px(8'd255, 8'd1, 8'd0, 8'd255), 1'b0, 1'b0);
    send_pixel(make_px(8'd255, 8'd255, 8'd255, 8'd255), 1'b0, 1'b1);
  endtask

  task automatic test_extremes();
    send_pixel(make_px(8'd0, 8'd0, 8'd0, 8'd0), 1'b1, 1'b0);
    send_pixel(make_px(8'd255, 8'd255, 8'd255, 8'd255), 1'b0, 1'b0);
    send_pixel(make_px(8'd128, 8'd127, 8'd128, 8'd128), 1'b0, 1'b0);
    send_pixel(make_px(8'd127, 8'd128, 8'd127, 8'd127), 1'b0, 1'b1);
  endtask

  // Run flush ahead of an RGBA chunk, then a restart that drops a pending run
  task automatic test_run_then_chunk();
    repeat (3) send_pixel(make_px(8'd5, 8'd6, 8'd7, 8'd9), 1'b0, 1'b0);
    send_pixel(make_px(8'd9, 8'd9, 8'd9, 8'd200), 1'b0, 1'b0);
    send_pixel(make_px(8'd9, 8'd9, 8'd9, 8'd200), 1'b0, 1'b0);
    send_pixel(make_px(8'd9, 8'd9, 8'd9, 8'd200), 1'b1, 1'b1);
  endtask

  // Three channels: alpha restarts at 255 on the first pixel
  task automatic test_three_channel();
    write_alpha_enable(1'b0);
    send_pixel(make_px(8'd3, 8'd3, 8'd3, 8'd17), 1'b1, 1'b0);
    send_pixel(make_px(8'd3, 8'd3, 8'd3, 8'd0), 1'b0, 1'b1);
  endtask

  // Switching to three channels keeps the alpha of the last pixel
  task automatic test_mode_change();
    write_alpha_enable(1'b1);
    send_pixel(make_px(8'd40, 8'd40, 8'd40, 8'd77), 1'b1, 1'b0);
    write_alpha_enable(1'b0);
    send_pixel(make_px(8'd41, 8'd40, 8'd40, 8'd5), 1'b0, 1'b0);
    send_pixel(make_px(8'd41, 8'd40, 8'd40, 8'd200), 1'b0, 1'b1);
  endtask

  // Receiver holds off while the sender keeps offering long chunks
  task automatic test_backpressure();
    int unsigned k;
    write_alpha_enable(1'b1);
    idle_pct     = 0;
    hold_off_req = 1'b1;
    for (k = 0; k < 30; k++) begin
      send_pixel(pixel_t'($urandom()), (k == 0), (k == 29));
    end
    wait_idle();
  endtask

  // Random images: runs, small and medium deltas, index reuse and noise flags
  task automatic test_random_images();
    pixel_t      cur;
    pixel_t      seen[$];
    int unsigned made, n_pix, k, kind, reps;
    int          t;
    bit          first_flag, last_flag;
    made = 0;
    cur  = ResetPixel;
    while (made < 350) begin
      if ($urandom_range(3) == 0) write_alpha_enable(1'($urandom_range(1)));
      case ($urandom_range(2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 40;
      endcase
      n_pix = ($urandom_range(9) == 0) ? $urandom_range(60, 30) : $urandom_range(20, 1);
      k = 0;
      while (k < n_pix) begin
        kind = $urandom_range(99);
        reps = 1;
        if (k == 0) begin
          cur = pixel_t'($urandom());
        end else if (kind < 25) begin
          reps = ($urandom_range(12) == 0) ? $urandom_range(70, 55) : $urandom_range(5, 1);
        end else if (kind < 45) begin
          cur.r = cur.r + 8'($urandom_range(3)) - 8'd2;
          cur.g = cur.g + 8'($urandom_range(3)) - 8'd2;
          cur.b = cur.b + 8'($urandom_range(3)) - 8'd2;
        end else if (kind < 60) begin
          t     = int'($urandom_range(63)) - 32;
          cur.g = cur.g + 8'(t);
          cur.r = cur.r + 8'(t + int'($urandom_range(15)) - 8);
          cur.b = cur.b + 8'(t + int'($urandom_range(15)) - 8);
        end else if (kind < 72 && seen.size() != 0) begin
          cur = seen[$urandom_range(seen.size() - 1)];
        end else if (kind < 87) begin
          cur.r = 8'($urandom());
          cur.g = 8'($urandom());
          cur.b = 8'($urandom());
        end else begin
          cur = pixel_t'($urandom());
        end
        seen.push_back(cur);
        if (seen.size() > 16) void'(seen.pop_front());
        repeat (reps) begin
          first_flag = (k == 0) || ($urandom_range(49) == 0);
          last_flag  = (k + 1 >= n_pix) || ($urandom_range(49) == 0);
          send_pixel(cur, first_flag, last_flag);
          k++;
          made++;
        end
      end
    end
  endtask

  initial begin
    clear_encoder_state();
    alpha_en_mirror = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_chunk_types();
    test_extremes();
    test_run_then_chunk();
    test_three_channel();
    test_mode_change();
    test_backpressure();
    test_random_images();
    wait_idle();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[qoi_pixel_encoder.f]
+incdir+rtl/core
rtl/core/qoi_pkg.sv
rtl/core/qoi_front.sv
rtl/core/qoi_cmd_fifo.sv
rtl/core/qoi_back.sv
rtl/core/qoi_pixel_encoder.sv
bench/qoi_pixel_encoder_test.sv
